/* hw/rtl/particle_verlet_update_unit_assert.svh */
// Assertion macros used by the particle update top level.
`ifndef PARTICLE_VERLET_UPDATE_UNIT_ASSERT_SVH
`define PARTICLE_VERLET_UPDATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PVU_ASSERT_IMPL(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define PVU_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define PVU_ASSERT_IMPL(label, a, b)
`define PVU_ASSERT_NEXT(label, a, b)
`endif
`endif

/* hw/rtl/pvu_pkg.sv */
// Shared constants, control types and helpers of the particle update unit.
package pvu_pkg;
    localparam int NUM_KINDS     = 4;
    localparam int MAX_PARTICLES = 65536;
    localparam int DIMENSIONS    = 3;
    localparam int DIV_W         = 39;
    localparam int DIV_CNT_W     = 6;

    localparam logic [2:0] REG_TIME_STEP      = 3'd0;
    localparam logic [2:0] REG_VELOCITY_SCALE = 3'd1;
    localparam logic [2:0] REG_MATCH_ALL      = 3'd2;
    localparam logic [2:0] REG_ACTIVE_GROUP   = 3'd3;
    localparam logic [2:0] REG_MASS_KIND0     = 3'd4;
    localparam logic [2:0] REG_MASS_KIND1     = 3'd5;
    localparam logic [2:0] REG_MASS_KIND2     = 3'd6;
    localparam logic [2:0] REG_MASS_KIND3     = 3'd7;

    localparam logic [1:0] MODE_VERLET_START  = 2'd0;
    localparam logic [1:0] MODE_VERLET_FINISH = 2'd1;
    localparam logic [1:0] MODE_EULER         = 2'd2;
    localparam logic [1:0] MODE_REPORT        = 2'd3;

    typedef enum logic [3:0] {
        LOP_NONE,
        LOP_LOAD,
        LOP_SCALE_MUL,
        LOP_SCALE_FIX,
        LOP_KICK_MUL,
        LOP_DIV_LOAD,
        LOP_DIV_STEP,
        LOP_KICK_FIX,
        LOP_DRIFT_MUL,
        LOP_DRIFT_FIX,
        LOP_ACC_MUL
    } lane_op_t;

    typedef struct packed {
        lane_op_t op;
        logic     full_kick;
    } lane_ctrl_t;

    typedef enum logic [2:0] {
        AOP_NONE,
        AOP_SUM,
        AOP_MUL,
        AOP_ADD,
        AOP_CLEAR
    } acc_op_t;

    typedef struct packed {
        acc_op_t op;
    } acc_ctrl_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction
endpackage

/* hw/rtl/pvu_lane.sv */
// One axis lane: shared multiplier, bit-serial divider and the kick/drift update.
module pvu_lane (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pvu_pkg::lane_ctrl_t      ctrl,
    input  logic signed [31:0]       pos_in,
    input  logic signed [31:0]       vel_in,
    input  logic signed [31:0]       force_in,
    input  logic [15:0]              time_step,
    input  logic [15:0]              velocity_scale,
    input  logic [15:0]              mass,
    output logic signed [31:0]       pos,
    output logic signed [31:0]       vel,
    output logic signed [48:0]       mom_term,
    output logic [62:0]              sq_term
);
    import pvu_pkg::*;

    logic signed [31:0]      pos_reg, vel_reg, force_reg;
    logic signed [48:0]      prod_reg, mom_reg;
    logic                    neg_reg;
    logic [DIV_W-1:0]        quo_reg;
    logic [15:0]             rem_reg;
    logic [62:0]             sq_reg;

    logic signed [31:0]      mul_a;
    logic signed [16:0]      mul_b;
    logic signed [48:0]      mul_a_ext, mul_b_ext, mul_res;
    logic signed [48:0]      scale_rnd, drift_rnd, scale_sh, drift_sh;
    logic [48:0]             mag;
    logic [16:0]             rem_sh;
    logic                    ge;
    logic signed [63:0]      q_s, kick_sum, drift_sum;
    logic [31:0]             vel_abs;
    logic [63:0]             sq_full;

    always_comb
    begin
        mul_a = (ctrl.op == LOP_KICK_MUL) ? force_reg : vel_reg;
        case (ctrl.op)
            LOP_SCALE_MUL: mul_b = $signed({1'b0, velocity_scale});
            LOP_ACC_MUL:   mul_b = $signed({1'b0, mass});
            default:       mul_b = $signed({1'b0, time_step});
        endcase
        mul_a_ext = 49'(mul_a);
        mul_b_ext = 49'(mul_b);
        mul_res   = mul_a_ext * mul_b_ext;

        // Arithmetic shifts round toward minus infinity, so negative products are biased first.
        scale_rnd = prod_reg + (prod_reg[48] ? 49'sd16383 : 49'sd0);
        scale_sh  = scale_rnd >>> 14;
        drift_rnd = prod_reg + (prod_reg[48] ? 49'sd65535 : 49'sd0);
        drift_sh  = drift_rnd >>> 16;
        drift_sum = 64'(pos_reg) + 64'(drift_sh);

        mag    = prod_reg[48] ? 49'(-prod_reg) : 49'(prod_reg);
        rem_sh = {rem_reg, quo_reg[DIV_W-1]};
        ge     = rem_sh >= {1'b0, mass};

        q_s      = $signed({25'd0, quo_reg});
        kick_sum = 64'(vel_reg) + (neg_reg ? -q_s : q_s);

        vel_abs = vel_reg[31] ? 32'(-vel_reg) : 32'(vel_reg);
        sq_full = 64'(vel_abs) * 64'(vel_abs);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            vel_reg   <= '0;
            force_reg <= '0;
            prod_reg  <= '0;
            mom_reg   <= '0;
            neg_reg   <= 1'b0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            sq_reg    <= '0;
        end
        else
        begin
            case (ctrl.op) inside
                LOP_LOAD:
                begin
                    pos_reg   <= pos_in;
                    vel_reg   <= vel_in;
                    force_reg <= force_in;
                end
                LOP_SCALE_MUL, LOP_KICK_MUL, LOP_DRIFT_MUL: prod_reg <= mul_res;
                LOP_SCALE_FIX: vel_reg <= sat32(64'(scale_sh));
                LOP_DIV_LOAD:
                begin
                    neg_reg <= prod_reg[48];
                    rem_reg <= 16'd0;
                    quo_reg <= ctrl.full_kick ? mag[46:8] : mag[47:9];
                end
                LOP_DIV_STEP:
                begin
                    rem_reg <= ge ? 16'(rem_sh - {1'b0, mass}) : rem_sh[15:0];
                    quo_reg <= {quo_reg[DIV_W-2:0], ge};
                end
                LOP_KICK_FIX:  vel_reg <= sat32(kick_sum);
                LOP_DRIFT_FIX: pos_reg <= sat32(drift_sum);
                LOP_ACC_MUL:
                begin
                    mom_reg <= mul_res;
                    sq_reg  <= sq_full[62:0];
                end
                default: ;
            endcase
        end
    end

    assign pos      = pos_reg;
    assign vel      = vel_reg;
    assign mom_term = mom_reg;
    assign sq_term  = sq_reg;
endmodule

/* hw/rtl/pvu_accum.sv */
// Merging stage: combines the lane terms into the saturating running sums.
module pvu_accum (
    input  logic                clk,
    input  logic                rst_n,
    input  pvu_pkg::acc_ctrl_t  ctrl,
    input  logic signed [48:0]  mom_term [pvu_pkg::DIMENSIONS],
    input  logic [62:0]         sq_term [pvu_pkg::DIMENSIONS],
    input  logic [15:0]         mass,
    output logic signed [63:0]  momentum [pvu_pkg::DIMENSIONS],
    output logic [62:0]         energy,
    output logic [16:0]         count
);
    import pvu_pkg::*;

    localparam logic [63:0] ENERGY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    logic signed [63:0] mom_reg [DIMENSIONS];
    logic signed [63:0] mom_next [DIMENSIONS];
    logic [62:0]        energy_reg;
    logic [16:0]        count_reg;
    logic [63:0]        sq_total_reg, sq_total;
    logic [55:0]        term_hi_reg;
    logic [15:0]        term_lo_reg;
    logic [39:0]        lo_prod;
    logic [56:0]        term;
    logic [63:0]        esum;
    logic signed [64:0] msum [DIMENSIONS];

    always_comb
    begin
        sq_total = 64'd0;
        for (int d = 0; d < DIMENSIONS; d++)
        begin
            sq_total = sq_total + 64'(sq_term[d]);
            msum[d]  = 65'(mom_reg[d]) + 65'(mom_term[d]);
            if (msum[d][64] != msum[d][63])
                mom_next[d] = msum[d][64] ? 64'sh8000_0000_0000_0000 :
                                            64'sh7FFF_FFFF_FFFF_FFFF;
            else
                mom_next[d] = msum[d][63:0];
        end
        lo_prod = 40'(sq_total_reg[23:0]) * 40'(mass);
        term    = 57'(term_hi_reg) + 57'(term_lo_reg);
        esum    = 64'(energy_reg) + 64'(term);
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            AOP_SUM: sq_total_reg <= sq_total;
            AOP_MUL:
            begin
                term_hi_reg <= 56'(sq_total_reg[63:24]) * 56'(mass);
                term_lo_reg <= lo_prod[39:24];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < DIMENSIONS; d++)
                mom_reg[d] <= 64'sd0;
            energy_reg <= 63'd0;
            count_reg  <= 17'd0;
        end
        else
        begin
            case (ctrl.op)
                AOP_SUM:
                    for (int d = 0; d < DIMENSIONS; d++)
                        mom_reg[d] <= mom_next[d];
                AOP_ADD:
                begin
                    energy_reg <= (esum > ENERGY_MAX) ? ENERGY_MAX[62:0] : esum[62:0];
                    if (count_reg < 17'(MAX_PARTICLES))
                        count_reg <= count_reg + 17'd1;
                end
                AOP_CLEAR:
                begin
                    for (int d = 0; d < DIMENSIONS; d++)
                        mom_reg[d] <= 64'sd0;
                    energy_reg <= 63'd0;
                    count_reg  <= 17'd0;
                end
                default: ;
            endcase
        end
    end

    assign momentum = mom_reg;
    assign energy   = energy_reg;
    assign count    = count_reg;
endmodule

/* hw/rtl/particle_verlet_update_unit.sv */
// Top level of the particle velocity Verlet / symplectic Euler update unit.
// One particle beat is taken at a time and worked on by three axis lanes in parallel.
// A report beat or a particle outside the active group goes straight from accept to
// the done state; updates first pass through the 39-step bit-serial divider in each
// lane that divides the kick by the particle mass.
// A finished result waits in the output register, so the next particle is accepted
// as soon as the sequencer is back in idle.
`include "particle_verlet_update_unit_assert.svh"
module particle_verlet_update_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // group_id[7:0], atom_kind[9:8], pos_x/y/z, vel_x/y/z, force_x/y/z (32 each) from bit 10
    input  logic [303:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // new_pos_x/y/z, new_vel_x/y/z (32 each), momentum_x/y/z (64 each),
    // mass_speed_sq_sum (63), particle_count (17)
    output logic [463:0] m_axis_tdata,
    // was_updated[0]
    output logic         m_axis_tuser
);
    import pvu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCALE_MUL, S_SCALE_FIX, S_KICK_MUL, S_DIV_LOAD, S_DIV, S_KICK_FIX,
        S_DRIFT_MUL, S_DRIFT_FIX, S_ACC_MUL, S_ACC_SUM, S_ACC_E, S_ACC_ADD, S_DONE
    } state_t;

    state_t               state_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [1:0]           mode_reg;
    logic                 upd_reg;
    logic [15:0]          mass_cur_reg;
    logic                 out_valid_reg;
    logic [463:0]         out_data_reg;
    logic                 out_user_reg;

    logic [15:0] time_step_reg, vscale_reg, mass_reg [4];
    logic        match_all_reg;
    logic [7:0]  active_group_reg;

    logic               in_acc, out_load, match;
    logic [1:0]         kind_eff;
    logic [15:0]        mass_sel, mass_fix;
    lane_ctrl_t         lane_ctrl;
    acc_ctrl_t          acc_ctrl;
    logic signed [31:0] pos_in [DIMENSIONS], vel_in [DIMENSIONS], force_in [DIMENSIONS];
    logic signed [31:0] pos_o [DIMENSIONS], vel_o [DIMENSIONS];
    logic signed [48:0] mom_term [DIMENSIONS];
    logic [62:0]        sq_term [DIMENSIONS];
    logic signed [63:0] momentum [DIMENSIONS];
    logic [62:0]        energy;
    logic [16:0]        count;
    logic               report;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg    <= 16'd256;
            vscale_reg       <= 16'd16384;
            match_all_reg    <= 1'b1;
            active_group_reg <= 8'd0;
            for (int k = 0; k < 4; k++)
                mass_reg[k] <= 16'd256;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TIME_STEP:      time_step_reg    <= cfg_wdata;
                REG_VELOCITY_SCALE: vscale_reg       <= cfg_wdata;
                REG_MATCH_ALL:      match_all_reg    <= cfg_wdata[0];
                REG_ACTIVE_GROUP:   active_group_reg <= cfg_wdata[7:0];
                REG_MASS_KIND0:     mass_reg[0]      <= cfg_wdata;
                REG_MASS_KIND1:     mass_reg[1]      <= cfg_wdata;
                REG_MASS_KIND2:     mass_reg[2]      <= cfg_wdata;
                REG_MASS_KIND3:     mass_reg[3]      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);
    assign report        = (mode_reg == MODE_REPORT);

    always_comb
    begin
        kind_eff = ({1'b0, s_axis_tdata[9:8]} >= 3'(NUM_KINDS)) ? 2'(NUM_KINDS - 1)
                                                                 : s_axis_tdata[9:8];
        mass_sel = mass_reg[kind_eff];
        mass_fix = (mass_sel == 16'd0) ? 16'd1 : mass_sel;
        match    = match_all_reg || (s_axis_tdata[7:0] == active_group_reg);
        for (int d = 0; d < DIMENSIONS; d++)
        begin
            pos_in[d]   = s_axis_tdata[10 + 32*d +: 32];
            vel_in[d]   = s_axis_tdata[106 + 32*d +: 32];
            force_in[d] = s_axis_tdata[202 + 32*d +: 32];
        end
    end

    always_comb
    begin
        lane_ctrl.full_kick = (mode_reg == MODE_EULER);
        acc_ctrl.op         = AOP_NONE;
        unique case (state_reg)
            S_IDLE:      lane_ctrl.op = in_acc ? LOP_LOAD : LOP_NONE;
            S_SCALE_MUL: lane_ctrl.op = LOP_SCALE_MUL;
            S_SCALE_FIX: lane_ctrl.op = LOP_SCALE_FIX;
            S_KICK_MUL:  lane_ctrl.op = LOP_KICK_MUL;
            S_DIV_LOAD:  lane_ctrl.op = LOP_DIV_LOAD;
            S_DIV:       lane_ctrl.op = LOP_DIV_STEP;
            S_KICK_FIX:  lane_ctrl.op = LOP_KICK_FIX;
            S_DRIFT_MUL: lane_ctrl.op = LOP_DRIFT_MUL;
            S_DRIFT_FIX: lane_ctrl.op = LOP_DRIFT_FIX;
            S_ACC_MUL:   lane_ctrl.op = LOP_ACC_MUL;
            S_ACC_SUM:
            begin
                lane_ctrl.op = LOP_NONE;
                acc_ctrl.op  = AOP_SUM;
            end
            S_ACC_E:
            begin
                lane_ctrl.op = LOP_NONE;
                acc_ctrl.op  = AOP_MUL;
            end
            S_ACC_ADD:
            begin
                lane_ctrl.op = LOP_NONE;
                acc_ctrl.op  = AOP_ADD;
            end
            S_DONE:
            begin
                lane_ctrl.op = LOP_NONE;
                if (out_load && report)
                    acc_ctrl.op = AOP_CLEAR;
            end
            default: lane_ctrl.op = LOP_NONE;
        endcase
    end

    for (genvar d = 0; d < DIMENSIONS; d++)
    begin : g_lane
        pvu_lane u_lane (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctrl           (lane_ctrl),
            .pos_in         (pos_in[d]),
            .vel_in         (vel_in[d]),
            .force_in       (force_in[d]),
            .time_step      (time_step_reg),
            .velocity_scale (vscale_reg),
            .mass           (mass_cur_reg),
            .pos            (pos_o[d]),
            .vel            (vel_o[d]),
            .mom_term       (mom_term[d]),
            .sq_term        (sq_term[d])
        );
    end

    pvu_accum u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (acc_ctrl),
        .mom_term (mom_term),
        .sq_term  (sq_term),
        .mass     (mass_cur_reg),
        .momentum (momentum),
        .energy   (energy),
        .count    (count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_cnt_reg   <= '0;
            mode_reg      <= MODE_VERLET_START;
            upd_reg       <= 1'b0;
            mass_cur_reg  <= 16'd1;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_acc)
                    begin
                        mode_reg     <= s_axis_tuser;
                        mass_cur_reg <= mass_fix;
                        upd_reg      <= match && (s_axis_tuser != MODE_REPORT);
                        if (!match || s_axis_tuser == MODE_REPORT)
                            state_reg <= S_DONE;
                        else if (s_axis_tuser == MODE_VERLET_START)
                            state_reg <= S_SCALE_MUL;
                        else
                            state_reg <= S_KICK_MUL;
                    end
                S_SCALE_MUL: state_reg <= S_SCALE_FIX;
                S_SCALE_FIX: state_reg <= S_KICK_MUL;
                S_KICK_MUL:  state_reg <= S_DIV_LOAD;
                S_DIV_LOAD:
                begin
                    div_cnt_reg <= '0;
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    if (div_cnt_reg == DIV_CNT_W'(DIV_W - 1))
                        state_reg <= S_KICK_FIX;
                end
                S_KICK_FIX:
                    state_reg <= (mode_reg == MODE_VERLET_FINISH) ? S_ACC_MUL : S_DRIFT_MUL;
                S_DRIFT_MUL: state_reg <= S_DRIFT_FIX;
                S_DRIFT_FIX:
                    state_reg <= (mode_reg == MODE_EULER) ? S_ACC_MUL : S_DONE;
                S_ACC_MUL:   state_reg <= S_ACC_SUM;
                S_ACC_SUM:   state_reg <= S_ACC_E;
                S_ACC_E:     state_reg <= S_ACC_ADD;
                S_ACC_ADD:   state_reg <= S_DONE;
                S_DONE:
                    if (out_load)
                    begin
                        out_user_reg  <= upd_reg;
                        out_data_reg  <= {
                            report ? count : 17'd0,
                            report ? energy : 63'd0,
                            report ? momentum[2] : 64'sd0,
                            report ? momentum[1] : 64'sd0,
                            report ? momentum[0] : 64'sd0,
                            vel_o[2], vel_o[1], vel_o[0],
                            pos_o[2], pos_o[1], pos_o[0]
                        };
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    `PVU_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready)
    `PVU_ASSERT_NEXT(a_result_loaded, out_load, m_axis_tvalid)
    `PVU_ASSERT_IMPL(a_count_bounded, 1'b1, count <= 17'(MAX_PARTICLES))
endmodule
